// ----- hw/rtl/mec_pkg.sv -----
// Package for the escape-time counter: widths, constants and word types.
// No dependencies; used by every module of the core.
package mec_pkg;
    localparam int unsigned FRAC_BITS_DEF = 28;
    localparam int unsigned MAX_ITER_RST  = 1000;
    localparam int unsigned CW            = 32;
    localparam int unsigned ITW           = 16;
    localparam int unsigned QDEPTH        = 2;

    typedef struct packed {
        logic signed [CW-1:0] c_imag;
        logic signed [CW-1:0] c_real;
    } t_point;

    typedef struct packed {
        logic           inside_res;
        logic [ITW-1:0] escape_count;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } t_state;
endpackage

// ----- hw/rtl/mandelbrot_escape_count_core.sv -----
// Mandelbrot escape-time core: queue front end plus iteration engine.
// Each escape test is a multiply state then an update state; a point that runs N tests (N = 0 for a zero
// iteration limit) passes through load, N multiply/update pairs and output before its result word.
// The engine takes a new point only once its last result word has been taken.
// Two points queue in front so input is taken while the engine runs.
// Synchronous active-low reset empties the queue and sets the iteration limit to 1000.
module mandelbrot_escape_count_core import mec_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [ITW-1:0] i_cfg_wdata,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,  // c_real [31:0], c_imag [63:32]
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [23:0]    m_axis_tdata   // escape_count [15:0], inside_res [16], zero
);
    logic [ITW-1:0] r_iter_limit;
    logic   q_valid, q_ready;
    t_point q_data;
    t_result res;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_iter_limit <= ITW'(MAX_ITER_RST);
        else if (i_cfg_we) r_iter_limit <= i_cfg_wdata;
    end

    mec_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid (s_axis_tvalid),
        .o_wr_ready (s_axis_tready),
        .i_wr_data  (s_axis_tdata),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_data)
    );

    mec_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .i_clk, .i_rst_n,
        .i_iter_limit (r_iter_limit),
        .i_pt_valid   (q_valid),
        .o_pt_ready   (q_ready),
        .i_pt         (q_data),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (res)
    );

    assign m_axis_tdata = {7'd0, res};
endmodule

// ----- hw/rtl/mec_queue.sv -----
// Point queue between the input front and the iteration engine.
// Depends on mec_pkg.
module mec_queue import mec_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_valid,
    output logic   o_wr_ready,
    input  t_point i_wr_data,
    output logic   o_rd_valid,
    input  logic   i_rd_ready,
    output t_point o_rd_data
);
    t_point     r_mem [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_wr_ready = (r_cnt != 2'(QDEPTH));
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    // store word
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule

// ----- hw/rtl/mec_engine.sv -----
// Iteration engine: z = z*z + c with escape test, a multiply state then an update state per iteration.
// Depends on mec_pkg.
module mec_engine import mec_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [ITW-1:0] i_iter_limit,
    input  logic           i_pt_valid,
    output logic           o_pt_ready,
    input  t_point         i_pt,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output t_result        o_res
);
    localparam int unsigned PW = 2*CW;
    localparam logic signed [PW+1:0] LIMIT = (PW+2)'(4) <<< FRAC_BITS;
    localparam logic signed [PW+1:0] SMAX = (PW+2)'(33'sh0_7FFF_FFFF);
    localparam logic signed [PW+1:0] SMIN = -((PW+2)'(1) <<< (CW-1));

    t_state  r_st, n_st;
    logic signed [CW-1:0] r_zr, r_zi, r_cr, r_ci;
    logic signed [PW-1:0] r_pr, r_pi, r_px;
    logic [ITW-1:0] r_it;
    t_result r_res;

    logic signed [PW+1:0] sr, si, sum, nr, ni;
    logic signed [PW-1:0] px;

    // truncate products (arithmetic shift is floor)
    always_comb begin
        sr  = (PW+2)'(r_pr >>> FRAC_BITS);
        si  = (PW+2)'(r_pi >>> FRAC_BITS);
        px  = r_px >>> (FRAC_BITS-1);
        sum = sr + si;
        nr  = sr - si + (PW+2)'(r_cr);
        ni  = (PW+2)'(px) + (PW+2)'(r_ci);
    end

    assign o_pt_ready  = (r_st == ST_IDLE);
    assign o_res_valid = (r_st == ST_OUT);
    assign o_res       = r_res;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_pt_valid) n_st = (i_iter_limit == '0) ? ST_OUT : ST_MUL;
            ST_MUL:  n_st = ST_UPD;
            ST_UPD: begin
                if (sum > LIMIT || (r_it + ITW'(1)) == i_iter_limit) begin
                    n_st = ST_OUT;
                end else begin
                    n_st = ST_MUL;
                end
            end
            ST_OUT:  if (i_res_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    // datapath: load point, multiply, then update z or finish
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_cr <= i_pt.c_real;
                r_ci <= i_pt.c_imag;
                r_zr <= '0;
                r_zi <= '0;
                r_it <= '0;
                r_res.escape_count <= '0;
                r_res.inside_res   <= 1'b1;
            end
            ST_MUL: begin
                r_pr <= r_zr * r_zr;
                r_pi <= r_zi * r_zi;
                r_px <= r_zr * r_zi;
            end
            ST_UPD: begin
                if (sum > LIMIT) begin
                    r_res.escape_count <= r_it;
                    r_res.inside_res   <= 1'b0;
                end else begin
                    r_zr <= (nr > SMAX) ? SMAX[CW-1:0] : (nr < SMIN) ? SMIN[CW-1:0]
                          : nr[CW-1:0];
                    r_zi <= (ni > SMAX) ? SMAX[CW-1:0] : (ni < SMIN) ? SMIN[CW-1:0]
                          : ni[CW-1:0];
                    r_it <= r_it + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- tb/tb_mandelbrot_escape_count_core.sv -----
// Testbench for mandelbrot_escape_count_core: directed table then random points,
// checked against an escape-time predictor. Depends on mec_pkg and the core RTL.
module tb_mandelbrot_escape_count_core;
    import mec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned RAND_PHASES = 10;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [ITW-1:0] i_cfg_wdata = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [63:0]    s_axis_tdata = '0;   // c_real [31:0], c_imag [63:32]
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [23:0]    m_axis_tdata;        // escape_count [15:0], inside_res [16], zero

    mandelbrot_escape_count_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Directed row: either an iteration-limit write or a point, optionally with a typed result
    typedef struct {
        bit             is_cfg;
        logic [ITW-1:0] limit;
        logic [31:0]    re;
        logic [31:0]    im;
        bit             typed;
        logic [ITW-1:0] cnt;
        bit             ins;
    } t_row;

    t_row directed_rows [] = '{
        '{0, 0, 32'h0000_0000, 32'h0000_0000, 1, 0, 1},
        '{0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 0},
        '{0, 0, 32'h8000_0000, 32'h8000_0000, 1, 1, 0},
        '{0, 0, 32'he000_0000, 32'h0000_0000, 1, 0, 1},
        '{0, 0, 32'h2000_0000, 32'h0000_0000, 0, 0, 0},
        '{0, 0, 32'h0000_0000, 32'h2000_0000, 0, 0, 0},
        '{0, 0, 32'hf400_0000, 32'h0199_999a, 0, 0, 0},
        '{0, 0, 32'h0400_0001, 32'h0000_0000, 0, 0, 0},
        '{0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0},
        '{0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0, 0},
        '{0, 0, 32'h0000_0000, 32'h0000_0000, 1, 0, 1},
        '{0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0, 1},
        '{1, 1, 0, 0, 0, 0, 0},
        '{0, 0, 32'h0000_0000, 32'h0000_0000, 1, 0, 1},
        '{0, 0, 32'h7fff_ffff, 32'h0000_0000, 1, 0, 1},
        '{1, 2, 0, 0, 0, 0, 0},
        '{0, 0, 32'h7fff_ffff, 32'h0000_0000, 1, 1, 0},
        '{0, 0, 32'hf000_0000, 32'h0000_0000, 0, 0, 0},
        '{1, 16'hffff, 0, 0, 0, 0, 0},
        '{0, 0, 32'h1000_0000, 32'h0000_0000, 0, 0, 0},
        '{1, 16'd1000, 0, 0, 0, 0, 0},
        '{0, 0, 32'hc000_0000, 32'h0000_0000, 0, 0, 0}
    };

    int unsigned phase_limit [RAND_PHASES] = '{1, 16, 100, 37, 255, 500, 8, 3, 64, 65535};

    t_result     pending_results [$];
    int unsigned iter_limit = MAX_ITER_RST;
    int unsigned err_count = 0;
    int unsigned points_sent = 0;
    int unsigned results_seen = 0;
    int unsigned inside_seen = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;
    int unsigned stall_left = 0;

    // Escape-time count for one point under the given iteration limit
    function automatic t_result escape_time(t_point p, int unsigned limit);
        longint  zr, zi, sr, si, nr, ni, cr, ci;
        t_result r;
        cr = longint'(p.c_real);
        ci = longint'(p.c_imag);
        zr = 0;
        zi = 0;
        for (int unsigned k = 0; k < limit; k++) begin
            sr = (zr * zr) >>> FRAC_BITS_DEF;
            si = (zi * zi) >>> FRAC_BITS_DEF;
            if (sr + si > (longint'(4) <<< FRAC_BITS_DEF)) begin
                r.escape_count = k[ITW-1:0];
                r.inside_res = 1'b0;
                return r;
            end
            nr = sr - si + cr;
            ni = ((zr * zi) >>> (FRAC_BITS_DEF - 1)) + ci;
            zr = (nr > 64'sd2147483647) ? 64'sd2147483647 :
                 (nr < -64'sd2147483648) ? -64'sd2147483648 : nr;
            zi = (ni > 64'sd2147483647) ? 64'sd2147483647 :
                 (ni < -64'sd2147483648) ? -64'sd2147483648 : ni;
        end
        r.escape_count = '0;
        r.inside_res = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        err_count++;
    endtask

    // Offer one point, optionally after an idle burst; hold tvalid until accepted
    task automatic send_point(t_point p, bit typed, t_result want);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(typed ? want : escape_time(p, iter_limit));
        points_sent++;
    endtask

    // Drop valid, wait until every result is back, then let the engine settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [ITW-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        iter_limit = v;
    endtask

    function automatic t_point random_point();
        t_point p;
        if ($urandom_range(0, 3) == 0) begin
            p.c_real = $urandom;
            p.c_imag = $urandom;
        end else begin
            // region around the set: real in [-2.5, 0.5], imag in [-1.25, 1.25]
            p.c_real = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
            p.c_imag = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
        end
        return p;
    endfunction

    // Result side: check each word, then choose the next tready
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[ITW:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, escape_count", got.escape_count, -1);
            end else begin
                want = pending_results.pop_front();
                if (want.inside_res) inside_seen++;
                if (got.escape_count !== want.escape_count)
                    report_mismatch("escape_count", got.escape_count, want.escape_count);
                if (got.inside_res !== want.inside_res)
                    report_mismatch("inside_res", got.inside_res, want.inside_res);
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_point  p;
        t_result want;
        int unsigned n_items;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                write_limit(directed_rows[k].limit);
            end else begin
                p.c_real = directed_rows[k].re;
                p.c_imag = directed_rows[k].im;
                want.escape_count = directed_rows[k].cnt;
                want.inside_res = directed_rows[k].ins;
                send_point(p, directed_rows[k].typed, want);
            end
        end

        // Random phases; the final ones run without idling
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            write_limit(phase_limit[ph][ITW-1:0]);
            no_idle = (ph >= RAND_PHASES - 2);
            n_items = (phase_limit[ph] > 1000) ? 4 : 60;
            for (int unsigned n = 0; n < n_items; n++) begin
                if (phase_limit[ph] > 1000 && n == 0) begin
                    p = '0;
                end else begin
                    p = random_point();
                end
                send_point(p, 1'b0, want);
            end
        end

        drain();
        $display("run covered %0d points over %0d iteration limits, %0d results, %0d inside",
                 points_sent, RAND_PHASES + 5, results_seen, inside_seen);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/mec_pkg.sv
hw/rtl/mec_queue.sv
hw/rtl/mec_engine.sv
hw/rtl/mandelbrot_escape_count_core.sv
tb/tb_mandelbrot_escape_count_core.sv
